[sv/lru_cache_with_expiry_defines.svh]
// Assertion macros for the LRU cache with expiry.
// Needs clk and rst_n in scope at the point of use.
`ifndef LRU_CACHE_WITH_EXPIRY_DEFINES_SVH
`define LRU_CACHE_WITH_EXPIRY_DEFINES_SVH

`ifndef ASSERT_OFF
`define LCE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
`define LCE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define LCE_ASSERT_IMP(name, ante, cons)
`define LCE_ASSERT_NXT(name, ante, cons)
`endif

`endif

[sv/lce_pkg.sv]
// Shared types and constants for the LRU cache with expiry.
// No dependencies.
package lce_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int KEY_W = 64;
  localparam int TIME_W = 31;
  localparam int VAL_W = 16;
  localparam int TTL_W = 16;
  localparam int OUT_IDX_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [TTL_W-1:0] TTL_RESET = 16'd100;
  localparam logic [TIME_W-1:0] INV_RESET = '0;

  localparam logic [CFG_IDX_W-1:0] REG_TTL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV = 1'd1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] ft;
    logic [TIME_W-1:0] lu;
    logic [VAL_W-1:0]  val;
  } lce_row_t;

  typedef struct packed {
    logic stop;
    logic matched;
    logic fresh;
  } lce_scan_st_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } lce_state_t;

endpackage

[sv/lce_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on lce_pkg.
interface lce_in_if import lce_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] now;
  logic [VAL_W-1:0]  fill_value;

  modport source (output valid, key, now, fill_value, input ready);
  modport sink (input valid, key, now, fill_value, output ready);
endinterface

interface lce_out_if import lce_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [VAL_W-1:0]     value;
  logic                 hit;
  logic [OUT_IDX_W-1:0] entry_index;

  modport source (output valid, value, hit, entry_index, input ready);
  modport sink (input valid, value, hit, entry_index, output ready);
endinterface

[sv/lce_store.sv]
// Entry storage: one row memory plus per-row written flags.
// Depends on lce_pkg.
module lce_store import lce_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output lce_row_t      rd_row,
  output logic          rd_vld,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  lce_row_t      wr_row
);

  lce_row_t mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  lce_row_t rd_row_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_row = rd_row_r;
  assign rd_vld = rd_vld_r;

endmodule

[sv/lce_scan.sv]
// Scan compare unit: checks one entry per cycle for empty, key match and LRU age,
// and judges freshness of the match. Depends on lce_pkg.
module lce_scan import lce_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              chk_pend,
  input  logic [IW-1:0]     chk_idx,
  input  lce_row_t          row,
  input  logic              row_vld,
  input  logic [KEY_W-1:0]  req_key,
  input  logic [TIME_W-1:0] req_now,
  input  logic [TTL_W-1:0]  ttl,
  input  logic [TIME_W-1:0] inv,
  output lce_scan_st_t      st,
  output logic [IW-1:0]     slot,
  output logic [TIME_W-1:0] match_ft,
  output logic [VAL_W-1:0]  match_val
);

  logic matched_r, matched_nxt;
  logic empty_r, empty_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] lru_idx_r, lru_idx_nxt;
  logic [TIME_W-1:0] lru_age_r, lru_age_nxt;
  logic [TIME_W-1:0] match_ft_r, match_ft_nxt;
  logic [VAL_W-1:0] match_val_r, match_val_nxt;
  logic empty_here, match_here, last, older, fresh;

  always_comb begin
    empty_here = !row_vld || row.ft == '0;
    match_here = !empty_here && row.key == req_key;
    last = chk_idx == IW'(ENTRIES - 1);
    older = chk_idx == '0 || row.lu < lru_age_r;
    fresh = match_ft_r > inv &&
            ({1'b0, match_ft_r} + {{(TIME_W + 1 - TTL_W){1'b0}}, ttl}) > {1'b0, req_now};

    matched_nxt = matched_r;
    empty_nxt = empty_r;
    slot_nxt = slot_r;
    lru_idx_nxt = lru_idx_r;
    lru_age_nxt = lru_age_r;
    match_ft_nxt = match_ft_r;
    match_val_nxt = match_val_r;
    if (start) begin
      matched_nxt = 1'b0;
      empty_nxt = 1'b0;
    end else if (chk_pend) begin
      if (empty_here) begin
        empty_nxt = 1'b1;
        slot_nxt = chk_idx;
      end else if (match_here) begin
        matched_nxt = 1'b1;
        slot_nxt = chk_idx;
        match_ft_nxt = row.ft;
        match_val_nxt = row.val;
      end else if (older) begin
        lru_idx_nxt = chk_idx;
        lru_age_nxt = row.lu;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      matched_r <= matched_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    lru_idx_r <= lru_idx_nxt;
    lru_age_r <= lru_age_nxt;
    match_ft_r <= match_ft_nxt;
    match_val_r <= match_val_nxt;
  end

  assign st.stop = chk_pend && (empty_here || match_here || last);
  assign st.matched = matched_r;
  assign st.fresh = matched_r && fresh;
  assign slot = (matched_r || empty_r) ? slot_r : lru_idx_r;
  assign match_ft = match_ft_r;
  assign match_val = match_val_r;

endmodule

[sv/lru_cache_with_expiry.sv]
// Fully associative cache of 16-bit values with TTL expiry and LRU replacement.
//
// Usage:
//   in_bus  (sink): one request beat carries key, now and fill_value. The
//           block takes a beat only when idle (in_bus.ready high).
//   out_bus (source): one result beat per request: value, hit, entry_index.
//   cfg_*: write cfg_we with cfg_idx 0 for ttl, 1 for invalidate_time; only
//           while no request is in flight.
// Scan: the entries are read one per cycle from the row memory and checked
//   by the compare unit on the registered row; the scan stops at the first empty or
//   matching entry, or at the last entry. The chosen entry is then written
//   and the result registered, then loaded into the output register; the
//   next request is accepted the cycle after the result is loaded.
// Reset: all entries read as empty, ttl = 100, invalidate_time = 0.
// Stall: the result sits in an output register; while out_bus.ready is low
//   and the register is full, the block holds its finished result and takes
//   no new request.
// Depends on lce_pkg, lce_if, lce_store, lce_scan and the defines header.
`include "lru_cache_with_expiry_defines.svh"
module lru_cache_with_expiry import lce_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lce_in_if.sink                in_bus,
  lce_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  lce_state_t state_r, state_nxt;

  logic [KEY_W-1:0] req_key_r;
  logic [TIME_W-1:0] req_now_r;
  logic [VAL_W-1:0] req_fill_r;
  logic [TTL_W-1:0] ttl_r;
  logic [TIME_W-1:0] inv_r;

  logic [IW-1:0] rd_addr_r, rd_addr_nxt;
  logic [IW-1:0] chk_idx_r;
  logic pend_r, pend_nxt;

  logic res_hit_r;
  logic [VAL_W-1:0] res_val_r;
  logic [IW-1:0] res_idx_r;

  logic out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r;
  logic out_hit_r;
  logic [OUT_IDX_W-1:0] out_idx_r;

  logic in_ready, rd_en, wr_en, out_load, scan_start, in_acc;

  lce_row_t rd_row, wr_row;
  logic rd_vld;
  lce_scan_st_t scan_st;
  logic [IW-1:0] slot;
  logic [TIME_W-1:0] match_ft;
  logic [VAL_W-1:0] match_val;

  lce_store #(.ENTRIES(ENTRIES)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_row  (rd_row),
    .rd_vld  (rd_vld),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_row  (wr_row)
  );

  lce_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .chk_pend  (pend_r),
    .chk_idx   (chk_idx_r),
    .row       (rd_row),
    .row_vld   (rd_vld),
    .req_key   (req_key_r),
    .req_now   (req_now_r),
    .ttl       (ttl_r),
    .inv       (inv_r),
    .st        (scan_st),
    .slot      (slot),
    .match_ft  (match_ft),
    .match_val (match_val)
  );

  assign in_acc = in_bus.valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_st.stop) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: rd_en = 1'b1;
      ST_DECIDE: wr_en = 1'b1;
      ST_FINISH: out_load = !out_valid_r || out_bus.ready;
      default: ;
    endcase
    scan_start = in_acc;
  end

  always_comb begin
    wr_row.key = req_key_r;
    wr_row.ft = scan_st.fresh ? match_ft : req_now_r;
    wr_row.lu = req_now_r;
    wr_row.val = scan_st.fresh ? match_val : req_fill_r;

    rd_addr_nxt = rd_addr_r;
    pend_nxt = 1'b0;
    if (in_acc) begin
      rd_addr_nxt = '0;
    end else if (state_r == ST_SCAN) begin
      rd_addr_nxt = (rd_addr_r == IW'(ENTRIES - 1)) ? '0 : rd_addr_r + 1'b1;
      pend_nxt = !scan_st.stop;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      ttl_r <= TTL_RESET;
      inv_r <= INV_RESET;
    end else begin
      state_r <= state_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_TTL: ttl_r <= cfg_wdata[TTL_W-1:0];
          REG_INV: inv_r <= cfg_wdata[TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    chk_idx_r <= rd_addr_r;
    if (in_acc) begin
      req_key_r <= in_bus.key;
      req_now_r <= in_bus.now;
      req_fill_r <= in_bus.fill_value;
    end
    if (wr_en) begin
      res_hit_r <= scan_st.fresh;
      res_val_r <= wr_row.val;
      res_idx_r <= slot;
    end
    if (out_load) begin
      out_value_r <= res_val_r;
      out_hit_r <= res_hit_r;
      out_idx_r <= OUT_IDX_W'(res_idx_r);
    end
  end

  assign in_bus.ready = in_ready;
  assign out_bus.valid = out_valid_r;
  assign out_bus.value = out_value_r;
  assign out_bus.hit = out_hit_r;
  assign out_bus.entry_index = out_idx_r;

  `LCE_ASSERT_NXT(a_accept_scans, in_acc, state_r == ST_SCAN)
  `LCE_ASSERT_IMP(a_stop_in_scan, scan_st.stop, state_r == ST_SCAN)
  `LCE_ASSERT_IMP(a_slot_range, wr_en, slot <= IW'(ENTRIES - 1))
  `LCE_ASSERT_NXT(a_hit_needs_match, wr_en && scan_st.fresh, res_hit_r && scan_st.matched)

endmodule

[tb/lce_tb_pkg.sv]
// Scoreboard for the LRU cache with expiry: keeps its own copy of the entry
// table and registers, predicts one result per request and checks results.
// Depends on lce_pkg.
`timescale 1ns / 100ps
package lce_tb_pkg;
  import lce_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0]     value;
    logic                 hit;
    logic [OUT_IDX_W-1:0] entry_index;
  } lookup_res_t;

  class cache_scoreboard;
    logic [KEY_W-1:0]  row_key    [ENTRIES_DEF];
    logic [TIME_W-1:0] row_fill_t [ENTRIES_DEF];
    logic [TIME_W-1:0] row_use_t  [ENTRIES_DEF];
    logic [VAL_W-1:0]  row_val    [ENTRIES_DEF];
    logic [TTL_W-1:0]  ttl_r;
    logic [TIME_W-1:0] inv_r;
    lookup_res_t       due_q[$];
    int errors;
    int requests;
    int results;
    int fresh_hits;
    int stale_fills;
    int empty_fills;
    int evictions;

    function new();
      ttl_r = TTL_RESET;
      inv_r = INV_RESET;
      foreach (row_key[i]) begin
        row_key[i]    = '0;
        row_fill_t[i] = '0;
        row_use_t[i]  = '0;
        row_val[i]    = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TTL) ttl_r = data[TTL_W-1:0];
      else if (idx == REG_INV) inv_r = data[TIME_W-1:0];
    endfunction

    function void note_request(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now,
                               logic [VAL_W-1:0] fill);
      int hit_at;
      int empty_at;
      int lru_at;
      int slot;
      logic [TIME_W-1:0] lru_age;
      longint lo;
      longint bound;
      lookup_res_t res;
      requests++;
      hit_at = -1;
      empty_at = -1;
      lru_at = 0;
      lru_age = row_use_t[0];
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        if (row_fill_t[i] == '0) begin
          empty_at = i;
          break;
        end
        if (row_key[i] == key) begin
          hit_at = i;
          break;
        end
        if (row_use_t[i] < lru_age) begin
          lru_at = i;
          lru_age = row_use_t[i];
        end
      end
      if (hit_at >= 0) begin
        // signed window: now - ttl may go below zero
        lo = longint'(now) - longint'(ttl_r);
        bound = (lo > longint'(inv_r)) ? lo : longint'(inv_r);
        if (longint'(row_fill_t[hit_at]) > bound) begin
          row_use_t[hit_at] = now;
          res.value = row_val[hit_at];
          res.hit = 1'b1;
          res.entry_index = OUT_IDX_W'(hit_at);
          due_q.push_back(res);
          fresh_hits++;
          return;
        end
        slot = hit_at;
        stale_fills++;
      end else if (empty_at >= 0) begin
        slot = empty_at;
        row_key[slot] = key;
        empty_fills++;
      end else begin
        slot = lru_at;
        row_key[slot] = key;
        evictions++;
      end
      row_val[slot] = fill;
      row_fill_t[slot] = now;
      row_use_t[slot] = now;
      res.value = fill;
      res.hit = 1'b0;
      res.entry_index = OUT_IDX_W'(slot);
      due_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [VAL_W-1:0] value, logic hit, logic [OUT_IDX_W-1:0] idx);
      lookup_res_t want;
      results++;
      if (due_q.size() == 0) begin
        report($sformatf("result beat %0d with nothing outstanding: value=%h hit=%b idx=%0d",
                         results, value, hit, idx));
        return;
      end
      want = due_q.pop_front();
      if (value !== want.value)
        report($sformatf("result %0d value %h, want %h", results, value, want.value));
      if (hit !== want.hit)
        report($sformatf("result %0d hit %b, want %b", results, hit, want.hit));
      if (idx !== want.entry_index)
        report($sformatf("result %0d entry_index %0d, want %0d", results, idx,
                         want.entry_index));
    endtask
  endclass

endpackage

[tb/tb_top.sv]
// Top-level testbench for lru_cache_with_expiry: directed and random lookups
// under several ttl / invalidate settings, with random and long output stalls.
// Depends on lce_pkg, lce_if, lce_tb_pkg and the cache RTL.
`timescale 1ns / 100ps
module tb_top import lce_pkg::*, lce_tb_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lce_in_if in_bus ();
  lce_out_if out_bus ();

  cache_scoreboard sb = new();
  bit calm = 1'b0;
  int hold_reqs = 0;

  lru_cache_with_expiry u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // result side: check beats, random ready, occasional long hold-off
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.value, out_bus.hit, out_bus.entry_index);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= 18);
      end
    end
  end

  task automatic send_req(input logic [KEY_W-1:0] k, input logic [TIME_W-1:0] t,
                          input logic [VAL_W-1:0] f);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.key <= k;
    in_bus.now <= t;
    in_bus.fill_value <= f;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_request(k, t, f);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // keys mostly from a small pool so entries get hit, go stale and get evicted
  task automatic run_lookups(input int n, input int pool_n, input int step, input longint t0,
                             input int hold_at, input bit quiet);
    logic [KEY_W-1:0] pool [64];
    logic [KEY_W-1:0] k;
    logic [TIME_W-1:0] now_v;
    longint t;
    longint past;
    int r;
    for (int i = 0; i < 64; i++) pool[i] = {$urandom, $urandom};
    calm = quiet;
    t = t0;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_reqs++;
      r = $urandom_range(0, 99);
      k = (r < 90) ? pool[$urandom_range(0, pool_n - 1)] : {$urandom, $urandom};
      t += $urandom_range(0, step);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        past = t - $urandom_range(0, 200);
        if (past < 1) past = 1;
        now_v = past[TIME_W-1:0];
      end else if (r < 4) begin
        now_v = TIME_W'($urandom);
      end else begin
        now_v = t[TIME_W-1:0];
      end
      if (now_v == '0) now_v = 1;
      send_req(k, now_v, VAL_W'($urandom));
    end
    settle();
    calm = 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.key = '0;
    in_bus.now = '0;
    in_bus.fill_value = '0;
    ka = {$urandom, $urandom};
    kb = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, on reset register values
    send_req('0, 31'd1, 16'h0000);
    send_req('1, 31'd2, 16'hffff);
    send_req('0, 31'd50, 16'h1234);        // fresh hit, window below zero
    send_req('1, 31'd102, 16'h0005);       // fill time equal to bound: stale
    send_req('1, 31'd103, 16'h0006);
    send_req('0, 31'd101, 16'ha5a5);
    send_req(ka, 31'd0, 16'h0007);         // time zero leaves entry empty
    send_req(kb, 31'd200, 16'h0008);
    send_req(ka, 31'd201, 16'h0009);
    send_req('0, 31'h7fffffff, 16'hffff);
    send_req('0, 31'h7fffffff, 16'h0000);
    send_req('0, 31'd1, 16'h5a5a);         // time moved back
    for (int i = 0; i < 8; i++)
      send_req({$urandom, $urandom}, 31'(300 + i), VAL_W'($urandom));
    settle();

    set_reg(REG_TTL, {15'($urandom), 16'd100});
    set_reg(REG_INV, 31'd0);
    run_lookups(250, 12, 4, 1000, -1, 1'b0);

    set_reg(REG_TTL, {15'($urandom), 16'd0});
    run_lookups(200, 40, 1, 5000, -1, 1'b1);

    set_reg(REG_TTL, {15'($urandom), 16'hffff});
    set_reg(REG_INV, 31'd5100);
    run_lookups(250, 40, 3, 5200, 60, 1'b0);

    set_reg(REG_TTL, {15'($urandom), 16'd20});
    set_reg(REG_INV, 31'd0);
    run_lookups(250, 24, 8, 64'h7fffffff - 3000, -1, 1'b0);

    set_reg(REG_TTL, CFG_DATA_W'($urandom));
    set_reg(REG_INV, 31'h7fffffff);
    run_lookups(150, 16, 4, 20000, -1, 1'b0);

    set_reg(REG_TTL, {15'($urandom), 16'hffff});
    set_reg(REG_INV, 31'd0);
    run_lookups(400, 36, 2, 1, -1, 1'b0);

    $display("summary: %0d requests, %0d results: %0d fresh hits, %0d stale refills,",
             sb.requests, sb.results, sb.fresh_hits, sb.stale_fills);
    $display("summary: %0d empty fills, %0d LRU evictions, %0d mismatches",
             sb.empty_fills, sb.evictions, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
